### hdl/ftd_pkg.sv
// ----------------------------------------------------------------------------
// ftd_pkg
// Shared types, constants and helpers for the float to decimal text unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ftd_pkg;

   localparam int DESC_DEPTH_DEF = 2;
   localparam int OUT_DEPTH_DEF  = 4;

   localparam int BCD_DIGITS  = 16;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int INT_W       = 53;
   localparam int FRAC_W      = 52;
   localparam int DBL_ITER    = 53;
   localparam int SGL_ITER    = 24;
   localparam int DBL_LIMIT   = 15;
   localparam int SGL_LIMIT   = 6;
   localparam int SPEC_LEN    = 7;

   typedef struct packed {
      logic        mode;
      logic [63:0] raw_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic       range_error;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_NUM   = 2'd0,
      KIND_TEXT  = 2'd1,
      KIND_RANGE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic                   dbl;
      logic                   sign;
      logic                   dot;
      logic [INT_W-1:0]       int_value;
      logic [FRAC_W-1:0]      frac_value;
   } desc_type;

   function automatic logic [7:0] spec_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h69;
         3'd1:    c = 8'h6E;
         3'd2:    c = 8'h66;
         3'd3:    c = 8'h2F;
         3'd4:    c = 8'h6E;
         3'd5:    c = 8'h61;
         3'd6:    c = 8'h6E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### hdl/float_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// float_to_decimal_text_unit
// IEEE single/double bit pattern to decimal text, one character per
// transaction.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  request | req_push, req_full, req_data        | in
//  response| rsp_pop, rsp_empty, rsp_data       | out
//
//  Classification is combinational and lands in the queue at the accept
//  edge; the back end then loads the descriptor and, for a number, emits a
//  sign if negative, converts the 24 (single) or 53 (double) integer bits
//  by shift-and-add-3, skips leading zero digits and emits one character
//  at a time. Reset empties both queues and returns the sequencer to
//  idle. A full response queue stalls only the character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_decimal_text_unit #(
   parameter int DESC_DEPTH = ftd_pkg::DESC_DEPTH_DEF,
   parameter int OUT_DEPTH  = ftd_pkg::OUT_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire ftd_pkg::req_type  req_data,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output ftd_pkg::rsp_type       rsp_data
);

   ftd_pkg::desc_type desc_w, desc_q;
   ftd_pkg::rsp_type  out_data;
   logic              desc_empty, desc_pop, out_full, out_push;

   ftd_front u_front (
      .req  (req_data),
      .desc (desc_w)
   );

   ftd_fifo #(
      .WIDTH ($bits(ftd_pkg::desc_type)),
      .DEPTH (DESC_DEPTH)
   ) u_desc_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (desc_w),
      .full  (req_full),
      .pop   (desc_pop),
      .dout  (desc_q),
      .empty (desc_empty)
   );

   ftd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc       (desc_q),
      .desc_empty (desc_empty),
      .desc_pop   (desc_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   ftd_fifo #(
      .WIDTH ($bits(ftd_pkg::rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (rsp_data),
      .empty (rsp_empty)
   );

endmodule

`default_nettype wire

### hdl/ftd_fifo.sv
// ----------------------------------------------------------------------------
// ftd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module ftd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

### hdl/ftd_front.sv
// ----------------------------------------------------------------------------
// ftd_front
// Unpacks the IEEE pattern and classifies it into an integer part, a
// fraction aligned to 52 bits, and the text kind.
// ----------------------------------------------------------------------------
`default_nettype none

module ftd_front (
   input  wire ftd_pkg::req_type  req,
   output ftd_pkg::desc_type      desc
);

   logic               dbl;
   logic [63:0]        raw;
   logic [10:0]        ef, emax;
   logic [51:0]        frac_al;
   logic [52:0]        m_al, sig_n, vn, int_p, m_sh;
   logic signed [12:0] ex, mb, neg_sh;
   logic [5:0]         ex6;

   always_comb begin
      dbl     = req.mode;
      raw     = req.raw_bits;
      emax    = dbl ? 11'h7FF : 11'h0FF;
      ef      = dbl ? raw[62:52] : {3'b000, raw[30:23]};
      frac_al = dbl ? raw[51:0] : {raw[22:0], 29'b0};
      m_al    = {1'b1, frac_al};
      sig_n   = dbl ? m_al : {29'b0, 1'b1, raw[22:0]};
      mb      = dbl ? 13'sd52 : 13'sd23;
      ex      = $signed({2'b00, ef}) - (dbl ? 13'sd1023 : 13'sd127);
      neg_sh  = -ex;
      ex6     = ex[5:0];
      vn      = (neg_sh >= 13'sd64) ? '0 : (sig_n >> neg_sh[5:0]);
      int_p   = m_al >> (6'd52 - ex6);
      m_sh    = m_al << ex6;

      desc.kind       = ftd_pkg::KIND_NUM;
      desc.dbl        = dbl;
      desc.sign       = dbl ? raw[63] : raw[31];
      desc.dot        = 1'b0;
      desc.int_value  = '0;
      desc.frac_value = '0;

      if (ef == emax) begin
         desc.kind = ftd_pkg::KIND_TEXT;
      end else if (ef != '0 && ex > mb) begin
         desc.kind = ftd_pkg::KIND_RANGE;
      end else if (ef == '0) begin
         desc.dot = 1'b0;
      end else if (ex < 13'sd0) begin
         desc.dot        = 1'b1;
         desc.frac_value = dbl ? vn[51:0] : {vn[22:0], 29'b0};
      end else begin
         desc.int_value  = int_p;
         desc.frac_value = m_sh[51:0];
         desc.dot        = (ex == 13'sd0) || (m_sh[51:0] != '0);
      end
   end

endmodule

`default_nettype wire

### hdl/ftd_back.sv
// ----------------------------------------------------------------------------
// ftd_back
// Sequencer: binary to BCD by shift-and-add-3, then emits sign, integer
// digits, point and truncated fraction digits one per cycle while not full.
// ----------------------------------------------------------------------------
`default_nettype none

module ftd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ftd_pkg::desc_type  desc,
   input  wire logic               desc_empty,
   output logic                    desc_pop,
   input  wire logic               out_full,
   output logic                    out_push,
   output ftd_pkg::rsp_type        out_data
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SPECIAL = 7'b0000010,
      ST_SIGN    = 7'b0000100,
      ST_CONV    = 7'b0001000,
      ST_INT     = 7'b0010000,
      ST_DOT     = 7'b0100000,
      ST_FRAC    = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   ftd_pkg::kind_type               kind_ff, kind_in;
   logic                            dbl_ff, dbl_in;
   logic                            dot_ff, dot_in;
   logic                            started_ff, started_in;
   logic [ftd_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic [ftd_pkg::BCD_W-1:0]       bcd_ff, bcd_in, bcd_adj;
   logic [ftd_pkg::INT_W-1:0]       sh_ff, sh_in;
   logic [5:0]                      cnt_ff, cnt_in;
   logic [3:0]                      idx_ff, idx_in;
   logic [3:0]                      fcnt_ff, fcnt_in;
   logic [3:0]                      dig, limit;
   logic [55:0]                     times10;
   logic                            last_c;

   function automatic logic [ftd_pkg::BCD_W-1:0] add3(input logic [ftd_pkg::BCD_W-1:0] b);
      logic [ftd_pkg::BCD_W-1:0] r;
      r = b;
      for (int i = 0; i < ftd_pkg::BCD_DIGITS; i++) begin
         if (b[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = b[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      dbl_in     = dbl_ff;
      dot_in     = dot_ff;
      started_in = started_ff;
      frac_in    = frac_ff;
      bcd_in     = bcd_ff;
      sh_in      = sh_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      fcnt_in    = fcnt_ff;
      desc_pop   = 1'b0;
      out_push   = 1'b0;
      out_data   = '0;
      bcd_adj    = add3(bcd_ff);
      dig        = bcd_ff[{idx_ff, 2'b00} +: 4];
      limit      = dbl_ff ? 4'(ftd_pkg::DBL_LIMIT) : 4'(ftd_pkg::SGL_LIMIT);
      times10    = ({4'b0, frac_ff} << 3) + ({4'b0, frac_ff} << 1);
      last_c     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!desc_empty) begin
               desc_pop = 1'b1;
               kind_in  = desc.kind;
               dbl_in   = desc.dbl;
               dot_in   = desc.dot;
               frac_in  = desc.frac_value;
               bcd_in   = '0;
               sh_in    = desc.dbl ? desc.int_value : {desc.int_value[23:0], 29'b0};
               cnt_in   = desc.dbl ? 6'(ftd_pkg::DBL_ITER) : 6'(ftd_pkg::SGL_ITER);
               idx_in   = '0;
               if (desc.kind != ftd_pkg::KIND_NUM) begin
                  state_in = ST_SPECIAL;
               end else if (desc.sign) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_SPECIAL: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (kind_ff == ftd_pkg::KIND_RANGE) begin
                  out_data.character   = 8'h00;
                  out_data.last        = 1'b1;
                  out_data.range_error = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  last_c             = (idx_ff == 4'(ftd_pkg::SPEC_LEN - 1));
                  out_data.character = ftd_pkg::spec_char(idx_ff[2:0]);
                  out_data.last      = last_c;
                  idx_in             = idx_ff + 4'd1;
                  if (last_c) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_SIGN: begin
            if (!out_full) begin
               out_push           = 1'b1;
               out_data.character = 8'h2D;
               state_in           = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[ftd_pkg::BCD_W-2:0], sh_ff[ftd_pkg::INT_W-1]};
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in   = ST_INT;
               idx_in     = 4'(ftd_pkg::BCD_DIGITS - 1);
               started_in = 1'b0;
            end
         end
         ST_INT: begin
            if (dig == 4'd0 && !started_ff && idx_ff != 4'd0) begin
               idx_in = idx_ff - 4'd1;
            end else if (!out_full) begin
               out_push           = 1'b1;
               out_data.character = {4'h3, dig};
               out_data.last      = (idx_ff == 4'd0) && !dot_ff;
               started_in         = 1'b1;
               idx_in             = idx_ff - 4'd1;
               if (idx_ff == 4'd0) begin
                  state_in = dot_ff ? ST_DOT : ST_IDLE;
               end
            end
         end
         ST_DOT: begin
            if (!out_full) begin
               out_push           = 1'b1;
               out_data.character = 8'h2E;
               out_data.last      = (frac_ff == '0);
               fcnt_in            = '0;
               state_in           = (frac_ff == '0) ? ST_IDLE : ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (!out_full) begin
               last_c             = (times10[51:0] == '0) || (fcnt_ff == limit - 4'd1);
               out_push           = 1'b1;
               out_data.character = {4'h3, times10[55:52]};
               out_data.last      = last_c;
               frac_in            = times10[51:0];
               fcnt_in            = fcnt_ff + 4'd1;
               if (last_c) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      dbl_ff     <= dbl_in;
      dot_ff     <= dot_in;
      started_ff <= started_in;
      frac_ff    <= frac_in;
      bcd_ff     <= bcd_in;
      sh_ff      <= sh_in;
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      fcnt_ff    <= fcnt_in;
   end

endmodule

`default_nettype wire

### hdl/ftd_checker.sv
// ----------------------------------------------------------------------------
// ftd_checker
// Port-level checks on the float to decimal text unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ftd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_push,
   input wire logic              req_full,
   input wire ftd_pkg::req_type  req_data,
   input wire logic              rsp_pop,
   input wire logic              rsp_empty,
   input wire ftd_pkg::rsp_type  rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |-> !$isunknown(req_data))
      else $error("accepted request transaction carries unknown bits");

   a_range_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.range_error) |-> rsp_data.last)
      else $error("range error transaction not marked last");

   a_range_nul: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.range_error) |-> (rsp_data.character == 8'h00))
      else $error("range error transaction carries a character");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind float_to_decimal_text_unit ftd_checker u_ftd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_pop   (rsp_pop),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data)
);

`default_nettype wire
